// ===== src/cslex_pkg.sv =====
// ----------------------------------------------------------------------------
// cslex_pkg
// Shared types, character codes and keyword tables for the C subset lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package cslex_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_SLASH,
    MODE_LINEC,
    MODE_BLOCK,
    MODE_IDENT,
    MODE_NUM
  } scan_mode_e;

  localparam logic [1:0] KIND_OP      = 2'd0;
  localparam logic [1:0] KIND_KEYWORD = 2'd1;
  localparam logic [1:0] KIND_IDENT   = 2'd2;
  localparam logic [1:0] KIND_NUM     = 2'd3;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  localparam int NUM_KW = 6;

  // int, void, if, else, do, while
  localparam logic [7:0] KW_TEXT [NUM_KW][5] = '{
    '{8'h69, 8'h6E, 8'h74, 8'h00, 8'h00},
    '{8'h76, 8'h6F, 8'h69, 8'h64, 8'h00},
    '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00},
    '{8'h65, 8'h6C, 8'h73, 8'h65, 8'h00},
    '{8'h64, 8'h6F, 8'h00, 8'h00, 8'h00},
    '{8'h77, 8'h68, 8'h69, 8'h6C, 8'h65}
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd3, 3'd4, 3'd2, 3'd4, 3'd2, 3'd5};

  // controller -> datapath
  typedef struct packed {
    logic       load;
    logic       mode_wr;
    scan_mode_e mode_val;
    logic       star_wr;
    logic       star_val;
    logic       bump_line;
    logic       clear_lex;
    logic       append;
    logic       flush_start;
    logic       flush_emit;
    logic       emit_op;
    logic       op_is_slash;
  } cslex_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [7:0] byte_c;
    logic       eot;
    scan_mode_e mode;
    logic       star;
    logic       slot_free;
    logic       lex_empty;
    logic       flush_last;
  } cslex_sts_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return (c == 8'h2B) || (c == 8'h2D) || (c == CH_STAR) || (c == CH_SLASH) ||
           (c == 8'h3E) || (c == 8'h3C) || (c == 8'h3D) || (c == 8'h25) ||
           (c == 8'h26) || (c == 8'h7C);
  endfunction

  // keywords that still match with character c at position p
  function automatic logic [NUM_KW-1:0] kw_step(input logic [5:0] p, input logic [7:0] c);
    logic [NUM_KW-1:0] keep;
    keep = '0;
    for (int k = 0; k < NUM_KW; k++) begin
      if (p < {3'b000, KW_LEN[k]}) begin
        keep[k] = (KW_TEXT[k][p[2:0]] == c);
      end
    end
    return keep;
  endfunction

  function automatic logic kw_hit(input logic [NUM_KW-1:0] kw, input logic [5:0] len);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < NUM_KW; k++) begin
      if (kw[k] && (len == {3'b000, KW_LEN[k]})) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

// ===== src/cslex_ram.sv =====
// ----------------------------------------------------------------------------
// cslex_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cslex_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== src/cslex_ctrl.sv =====
// ----------------------------------------------------------------------------
// cslex_ctrl
// Lexer sequencer: decodes the latched byte against the scan mode and steps
// the datapath through comment skipping, appends, flushes and operator words.
// ----------------------------------------------------------------------------
`default_nettype none

module cslex_ctrl
  import cslex_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire cslex_sts_t sts_i,
  output cslex_cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    ST_WAIT,
    ST_DECODE,
    ST_FLUSH,
    ST_IDLEBYTE
  } state_e;

  state_e state_q, state_d;
  logic   after_idle_q, after_idle_d;
  logic   do_idle;
  logic [7:0] c;

  assign c          = sts_i.byte_c;
  assign in_ready_o = (state_q == ST_WAIT);

  always_comb begin
    cmd_o        = '0;
    state_d      = state_q;
    after_idle_d = after_idle_q;
    do_idle      = 1'b0;

    unique case (state_q)
      ST_WAIT: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end

      ST_DECODE: begin
        if (sts_i.eot) begin
          unique case (sts_i.mode)
            MODE_SLASH: begin
              if (sts_i.slot_free) begin
                cmd_o.emit_op     = 1'b1;
                cmd_o.op_is_slash = 1'b1;
                cmd_o.mode_wr     = 1'b1;
                cmd_o.mode_val    = MODE_IDLE;
                cmd_o.star_wr     = 1'b1;
                state_d           = ST_WAIT;
              end
            end
            MODE_IDENT, MODE_NUM: begin
              cmd_o.mode_wr  = 1'b1;
              cmd_o.mode_val = MODE_IDLE;
              cmd_o.star_wr  = 1'b1;
              if (sts_i.lex_empty) begin
                state_d = ST_WAIT;
              end else begin
                cmd_o.flush_start = 1'b1;
                after_idle_d      = 1'b0;
                state_d           = ST_FLUSH;
              end
            end
            MODE_LINEC: begin
              cmd_o.bump_line = 1'b1;
              cmd_o.mode_wr   = 1'b1;
              cmd_o.mode_val  = MODE_IDLE;
              cmd_o.star_wr   = 1'b1;
              state_d         = ST_WAIT;
            end
            default: begin
              cmd_o.mode_wr  = 1'b1;
              cmd_o.mode_val = MODE_IDLE;
              cmd_o.star_wr  = 1'b1;
              state_d        = ST_WAIT;
            end
          endcase
        end else begin
          unique case (sts_i.mode)
            MODE_SLASH: begin
              if (c == CH_SLASH) begin
                cmd_o.mode_wr  = 1'b1;
                cmd_o.mode_val = MODE_LINEC;
                state_d        = ST_WAIT;
              end else if (c == CH_STAR) begin
                cmd_o.mode_wr  = 1'b1;
                cmd_o.mode_val = MODE_BLOCK;
                cmd_o.star_wr  = 1'b1;
                state_d        = ST_WAIT;
              end else if (sts_i.slot_free) begin
                cmd_o.emit_op     = 1'b1;
                cmd_o.op_is_slash = 1'b1;
                cmd_o.mode_wr     = 1'b1;
                cmd_o.mode_val    = MODE_IDLE;
                state_d           = ST_IDLEBYTE;
              end
            end
            MODE_LINEC: begin
              if (c == CH_NL) begin
                cmd_o.bump_line = 1'b1;
                cmd_o.mode_wr   = 1'b1;
                cmd_o.mode_val  = MODE_IDLE;
              end
              state_d = ST_WAIT;
            end
            MODE_BLOCK: begin
              cmd_o.bump_line = (c == CH_NL);
              cmd_o.star_wr   = 1'b1;
              if (sts_i.star && (c == CH_SLASH)) begin
                cmd_o.mode_wr  = 1'b1;
                cmd_o.mode_val = MODE_IDLE;
              end else begin
                cmd_o.star_val = (c == CH_STAR);
              end
              state_d = ST_WAIT;
            end
            MODE_IDENT, MODE_NUM: begin
              if (is_digit(c) ||
                  ((sts_i.mode == MODE_IDENT) && (is_alpha(c) || (c == CH_UNDER)))) begin
                cmd_o.append = 1'b1;
                state_d      = ST_WAIT;
              end else begin
                cmd_o.mode_wr  = 1'b1;
                cmd_o.mode_val = MODE_IDLE;
                if (sts_i.lex_empty) begin
                  state_d = ST_IDLEBYTE;
                end else begin
                  cmd_o.flush_start = 1'b1;
                  after_idle_d      = 1'b1;
                  state_d           = ST_FLUSH;
                end
              end
            end
            default: begin
              do_idle = 1'b1;
            end
          endcase
        end
      end

      ST_FLUSH: begin
        if (sts_i.slot_free) begin
          cmd_o.flush_emit = 1'b1;
          if (sts_i.flush_last) begin
            state_d = after_idle_q ? ST_IDLEBYTE : ST_WAIT;
          end
        end
      end

      ST_IDLEBYTE: begin
        do_idle = 1'b1;
      end

      default: begin
        state_d = ST_WAIT;
      end
    endcase

    // fresh byte with no token pending
    if (do_idle) begin
      cmd_o.mode_wr  = 1'b1;
      cmd_o.mode_val = MODE_IDLE;
      state_d        = ST_WAIT;
      priority if (c == CH_SLASH) begin
        cmd_o.mode_val = MODE_SLASH;
      end else if (is_op(c)) begin
        if (sts_i.slot_free) begin
          cmd_o.emit_op = 1'b1;
        end else begin
          cmd_o.mode_wr = 1'b0;
          state_d       = state_q;
        end
      end else if (is_alpha(c) || (c == CH_UNDER)) begin
        cmd_o.clear_lex = 1'b1;
        cmd_o.append    = 1'b1;
        cmd_o.mode_val  = MODE_IDENT;
      end else if (is_digit(c)) begin
        cmd_o.clear_lex = 1'b1;
        cmd_o.append    = 1'b1;
        cmd_o.mode_val  = MODE_NUM;
      end else if (c == CH_NL) begin
        cmd_o.bump_line = 1'b1;
      end else begin
        cmd_o.mode_val = MODE_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_WAIT;
      after_idle_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      after_idle_q <= after_idle_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/cslex_datapath.sv =====
// ----------------------------------------------------------------------------
// cslex_datapath
// Scan state, lexeme buffer, keyword tracking, line and token counters, and
// the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module cslex_datapath
  import cslex_pkg::*;
#(
  parameter int MAX_LEXEME = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cslex_cmd_t  cmd_i,
  output cslex_sts_t       sts_o,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic        in_eot_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      out_line_o,
  output logic [15:0]      out_token_o,
  output logic [1:0]       out_kind_o,
  output logic [7:0]       out_char_o,
  output logic [4:0]       out_pos_o,
  output logic             out_last_o,
  output logic             out_trunc_o
);

  localparam int LW = $clog2(MAX_LEXEME + 1);
  localparam int AW = $clog2(MAX_LEXEME);

  logic [7:0]        byte_q;
  logic              eot_q;
  scan_mode_e        mode_q, mode_d;
  logic              star_q, star_d;
  logic [LW-1:0]     len_q, len_d;
  logic              ovf_q, ovf_d;
  logic [NUM_KW-1:0] kw_q, kw_d;
  logic [15:0]       line_q, line_d;
  logic [15:0]       tok_q, tok_d;

  logic [LW-1:0]     flen_q, fidx_q, fidx_inc;
  logic [1:0]        fkind_q;
  logic              ftrunc_q;

  logic              m_valid_q;
  logic [15:0]       o_line_q, o_tok_q;
  logic [1:0]        o_kind_q;
  logic [7:0]        o_char_q;
  logic [4:0]        o_pos_q;
  logic              o_last_q, o_trunc_q;

  logic [LW-1:0]     base_len;
  logic              base_ovf;
  logic [NUM_KW-1:0] base_kw;
  logic              clear;
  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [7:0]        rd_data;
  logic [LW+4:0]     pos_ext;
  logic              slot_free, flush_last;

  cslex_ram #(
    .WIDTH (8),
    .DEPTH (MAX_LEXEME)
  ) u_buf (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (byte_q),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign slot_free  = !m_valid_q || out_ready_i;
  assign fidx_inc   = fidx_q + LW'(1);
  assign flush_last = (fidx_inc == flen_q);
  assign pos_ext    = (LW + 5)'(fidx_q);

  assign sts_o.byte_c     = byte_q;
  assign sts_o.eot        = eot_q;
  assign sts_o.mode       = mode_q;
  assign sts_o.star       = star_q;
  assign sts_o.slot_free  = slot_free;
  assign sts_o.lex_empty  = (len_q == '0);
  assign sts_o.flush_last = flush_last;

  assign rd_en   = cmd_i.flush_start | cmd_i.flush_emit;
  assign rd_addr = cmd_i.flush_start ? '0 : fidx_inc[AW-1:0];

  // lexeme append / clear
  always_comb begin
    clear    = cmd_i.clear_lex | cmd_i.flush_start;
    base_len = clear ? '0 : len_q;
    base_ovf = clear ? 1'b0 : ovf_q;
    base_kw  = clear ? '1 : kw_q;
    len_d    = base_len;
    ovf_d    = base_ovf;
    kw_d     = base_kw;
    wr_en    = 1'b0;
    wr_addr  = base_len[AW-1:0];
    if (cmd_i.append) begin
      if (base_len < LW'(MAX_LEXEME)) begin
        wr_en = 1'b1;
        len_d = base_len + LW'(1);
        kw_d  = base_kw & kw_step(6'(base_len), byte_q);
      end else begin
        ovf_d = 1'b1;
        kw_d  = '0;
      end
    end
  end

  always_comb begin
    mode_d = cmd_i.mode_wr ? cmd_i.mode_val : mode_q;
    star_d = cmd_i.star_wr ? cmd_i.star_val : star_q;
    line_d = line_q;
    if (cmd_i.bump_line && (line_q != 16'hFFFF)) begin
      line_d = line_q + 16'd1;
    end
    tok_d = tok_q;
    if ((cmd_i.emit_op || (cmd_i.flush_emit && flush_last)) && (tok_q != 16'hFFFF)) begin
      tok_d = tok_q + 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      star_q    <= 1'b0;
      len_q     <= '0;
      ovf_q     <= 1'b0;
      kw_q      <= '1;
      line_q    <= 16'd1;
      tok_q     <= 16'd1;
      m_valid_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      star_q <= star_d;
      len_q  <= len_d;
      ovf_q  <= ovf_d;
      kw_q   <= kw_d;
      line_q <= line_d;
      tok_q  <= tok_d;
      if (cmd_i.emit_op || cmd_i.flush_emit) begin
        m_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      byte_q <= in_byte_i;
      eot_q  <= in_eot_i;
    end
    if (cmd_i.flush_start) begin
      flen_q   <= len_q;
      fidx_q   <= '0;
      ftrunc_q <= ovf_q;
      if (mode_q == MODE_NUM) begin
        fkind_q <= KIND_NUM;
      end else if (kw_hit(kw_q, 6'(len_q)) && !ovf_q) begin
        fkind_q <= KIND_KEYWORD;
      end else begin
        fkind_q <= KIND_IDENT;
      end
    end else if (cmd_i.flush_emit) begin
      fidx_q <= fidx_inc;
    end
    if (cmd_i.flush_emit) begin
      o_line_q  <= line_q;
      o_tok_q   <= tok_q;
      o_kind_q  <= fkind_q;
      o_char_q  <= rd_data;
      o_pos_q   <= pos_ext[4:0];
      o_last_q  <= flush_last;
      o_trunc_q <= ftrunc_q;
    end else if (cmd_i.emit_op) begin
      o_line_q  <= line_q;
      o_tok_q   <= tok_q;
      o_kind_q  <= KIND_OP;
      o_char_q  <= cmd_i.op_is_slash ? CH_SLASH : byte_q;
      o_pos_q   <= 5'd0;
      o_last_q  <= 1'b1;
      o_trunc_q <= 1'b0;
    end
  end

  assign out_valid_o = m_valid_q;
  assign out_line_o  = o_line_q;
  assign out_token_o = o_tok_q;
  assign out_kind_o  = o_kind_q;
  assign out_char_o  = o_char_q;
  assign out_pos_o   = o_pos_q;
  assign out_last_o  = o_last_q;
  assign out_trunc_o = o_trunc_q;

endmodule

`default_nettype wire

// ===== src/c_subset_lexer_core.sv =====
// ----------------------------------------------------------------------------
// c_subset_lexer_core
// Byte-serial lexer for a small C subset: skips comments, counts lines and
// emits each token as a run of character words.
// ----------------------------------------------------------------------------
// Timing: a byte is latched in one cycle and decoded in the next; an operator
//   word is registered into the output word register at decode.
// Flow: a new byte is accepted only once the last one is fully handled; a token
//   of n characters is read back one per cycle from the lexeme RAM, and the byte
//   that ends a token or follows a held slash is re-scanned; output stalls hold
//   the sequencer.
// Reset: scan mode idle, lexeme empty, line and token counters at 1.
// ----------------------------------------------------------------------------
`default_nettype none

module c_subset_lexer_core
  import cslex_pkg::*;
#(
  parameter int MAX_LEXEME = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // text_byte
  input  wire logic        s_axis_tlast_i,   // end_of_text
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [47:0]      m_axis_tdata_o,   // line_number, token_number, lexeme_char,
                                             // char_position, zero pad
  output logic [2:0]       m_axis_tuser_o,   // token_kind, lexeme_truncated
  output logic             m_axis_tlast_o    // last_of_token
);

  cslex_cmd_t  cmd;
  cslex_sts_t  sts;
  logic [15:0] line_number, token_number;
  logic [1:0]  token_kind;
  logic [7:0]  lexeme_char;
  logic [4:0]  char_position;
  logic        lexeme_truncated;

  cslex_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cslex_datapath #(
    .MAX_LEXEME (MAX_LEXEME)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_byte_i   (s_axis_tdata_i),
    .in_eot_i    (s_axis_tlast_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_line_o  (line_number),
    .out_token_o (token_number),
    .out_kind_o  (token_kind),
    .out_char_o  (lexeme_char),
    .out_pos_o   (char_position),
    .out_last_o  (m_axis_tlast_o),
    .out_trunc_o (lexeme_truncated)
  );

  assign m_axis_tdata_o = {3'b000, char_position, lexeme_char, token_number, line_number};
  assign m_axis_tuser_o = {lexeme_truncated, token_kind};

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream test of c_subset_lexer_core. A short table of source text hits the
// corner cases first, then random C-like fragments with random gaps and
// output stalls. Every character word is checked against a local lexer model.
// ----------------------------------------------------------------------------

module tb;
  import cslex_pkg::*;

  localparam int LEX_MAX   = 32;
  localparam int NDIR      = 26;
  localparam int RAND_ITEMS = 294;
  localparam int TAIL      = 64;
  localparam int LIMIT     = 4000000;

  typedef struct packed {
    logic [15:0] line;
    logic [15:0] tok;
    logic [1:0]  kind;
    logic [7:0]  ch;
    logic [4:0]  pos;
    logic        last;
    logic        trunc;
  } lex_word_t;

  typedef struct packed {
    logic [7:0] b;
    logic       eot;
  } text_item_t;

  typedef struct packed {
    logic [7:0] b;
    logic       eot;
    logic       chk;
    lex_word_t  want;
  } text_row_t;

  localparam lex_word_t NO_WORD = '0;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tready = 1'b0;
  logic        s_tready_o;
  logic        m_tvalid_o;
  logic [47:0] m_tdata_o;
  logic [2:0]  m_tuser_o;
  logic        m_tlast_o;

  always #1 clk_i = ~clk_i;

  c_subset_lexer_core #(.MAX_LEXEME(LEX_MAX)) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata_o),
    .m_axis_tuser_o  (m_tuser_o),
    .m_axis_tlast_o  (m_tlast_o)
  );

  // source text table: byte, end of text, typed check, typed word
  text_row_t dir_rows [NDIR] = '{
    '{"+", 1'b0, 1'b1, '{16'd1, 16'd1, KIND_OP, "+", 5'd0, 1'b1, 1'b0}},
    '{"\n", 1'b0, 1'b0, NO_WORD},
    '{"i", 1'b0, 1'b0, NO_WORD},
    '{"n", 1'b0, 1'b0, NO_WORD},
    '{"t", 1'b0, 1'b0, NO_WORD},
    '{" ", 1'b0, 1'b0, NO_WORD},
    '{"9", 1'b0, 1'b0, NO_WORD},
    '{"a", 1'b0, 1'b0, NO_WORD},
    '{"/", 1'b0, 1'b0, NO_WORD},
    '{"*", 1'b0, 1'b0, NO_WORD},
    '{"/", 1'b0, 1'b0, NO_WORD},
    '{"\n", 1'b0, 1'b0, NO_WORD},
    '{"*", 1'b0, 1'b0, NO_WORD},
    '{"/", 1'b0, 1'b0, NO_WORD},
    '{"/", 1'b0, 1'b0, NO_WORD},
    '{8'hFF, 1'b1, 1'b1, '{16'd3, 16'd5, KIND_OP, "/", 5'd0, 1'b1, 1'b0}},
    '{"/", 1'b0, 1'b0, NO_WORD},
    '{"/", 1'b0, 1'b0, NO_WORD},
    '{8'h00, 1'b1, 1'b0, NO_WORD},
    '{"/", 1'b0, 1'b0, NO_WORD},
    '{"*", 1'b0, 1'b0, NO_WORD},
    '{8'h55, 1'b1, 1'b0, NO_WORD},
    '{8'hFF, 1'b0, 1'b0, NO_WORD},
    '{8'h00, 1'b0, 1'b0, NO_WORD},
    '{"_", 1'b0, 1'b0, NO_WORD},
    '{"+", 1'b1, 1'b0, NO_WORD}
  };

  string kw_name [6] = '{"int", "void", "if", "else", "do", "while"};
  string op_chars   = "+-*/><=%&|";
  string head_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  string id_chars   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  string cm_chars   = "ab *\n/x*";

  // lexer model state
  scan_mode_e  mode_p = MODE_IDLE;
  logic        star_p = 1'b0;
  logic [7:0]  lex_mem [LEX_MAX];
  int          lex_len = 0;
  logic        lex_ovf = 1'b0;
  logic [15:0] line_cnt = 16'd1;
  logic [15:0] tok_cnt = 16'd1;

  lex_word_t   token_chars_q [$];
  text_item_t  text_q [$];
  int          push_cnt = 0;
  int          err_cnt = 0;
  int          n_bytes = 0;
  int          n_words = 0;
  int          n_tokens = 0;
  int          cycles = 0;
  bit          s_rush = 1'b0;
  bit          m_rush = 1'b0;

  function automatic bit ch_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit ch_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit ch_op(input logic [7:0] c);
    bit hit;
    hit = 1'b0;
    for (int i = 0; i < op_chars.len(); i++) begin
      if (op_chars[i] == c) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic void put_word(input logic [1:0] kind, input logic [7:0] ch, input int pos,
                                   input logic last, input logic tr);
    lex_word_t w;
    w.line  = line_cnt;
    w.tok   = tok_cnt;
    w.kind  = kind;
    w.ch    = ch;
    w.pos   = pos[4:0];
    w.last  = last;
    w.trunc = tr;
    token_chars_q.push_back(w);
    push_cnt++;
  endfunction

  function automatic void bump_line();
    if (line_cnt != 16'hFFFF) line_cnt++;
  endfunction

  function automatic void bump_tok();
    if (tok_cnt != 16'hFFFF) tok_cnt++;
  endfunction

  function automatic void emit_op(input logic [7:0] c);
    put_word(KIND_OP, c, 0, 1'b1, 1'b0);
    bump_tok();
  endfunction

  function automatic bit lex_is_keyword();
    bit hit;
    for (int k = 0; k < 6; k++) begin
      if (lex_len == kw_name[k].len()) begin
        hit = 1'b1;
        for (int i = 0; i < lex_len; i++) begin
          if (lex_mem[i] != kw_name[k][i]) hit = 1'b0;
        end
        if (hit) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void add_char(input logic [7:0] c);
    if (lex_len < LEX_MAX) begin
      lex_mem[lex_len] = c;
      lex_len++;
    end else begin
      lex_ovf = 1'b1;
    end
  endfunction

  function automatic void flush_lexeme();
    logic [1:0] kind;
    if (mode_p == MODE_NUM) kind = KIND_NUM;
    else if (!lex_ovf && lex_is_keyword()) kind = KIND_KEYWORD;
    else kind = KIND_IDENT;
    for (int i = 0; i < lex_len; i++) begin
      put_word(kind, lex_mem[i], i, i == lex_len - 1, lex_ovf);
    end
    if (lex_len > 0) bump_tok();
    lex_len = 0;
    lex_ovf = 1'b0;
    mode_p  = MODE_IDLE;
  endfunction

  function automatic void start_fresh(input logic [7:0] c);
    mode_p = MODE_IDLE;
    if (c == CH_SLASH) begin
      mode_p = MODE_SLASH;
    end else if (ch_op(c)) begin
      emit_op(c);
    end else if (ch_alpha(c) || c == CH_UNDER) begin
      lex_len = 0;
      lex_ovf = 1'b0;
      add_char(c);
      mode_p = MODE_IDENT;
    end else if (ch_digit(c)) begin
      lex_len = 0;
      lex_ovf = 1'b0;
      add_char(c);
      mode_p = MODE_NUM;
    end else if (c == CH_NL) begin
      bump_line();
    end
  endfunction

  function automatic void lex_predict(input logic [7:0] c, input logic eot);
    if (eot) begin
      case (mode_p)
        MODE_SLASH: emit_op(CH_SLASH);
        MODE_IDENT, MODE_NUM: flush_lexeme();
        MODE_LINEC: bump_line();
        default: ;
      endcase
      mode_p = MODE_IDLE;
      star_p = 1'b0;
    end else begin
      case (mode_p)
        MODE_SLASH: begin
          if (c == CH_SLASH) begin
            mode_p = MODE_LINEC;
          end else if (c == CH_STAR) begin
            mode_p = MODE_BLOCK;
            star_p = 1'b0;
          end else begin
            emit_op(CH_SLASH);
            start_fresh(c);
          end
        end
        MODE_LINEC: begin
          if (c == CH_NL) begin
            bump_line();
            mode_p = MODE_IDLE;
          end
        end
        MODE_BLOCK: begin
          if (c == CH_NL) bump_line();
          if (star_p && c == CH_SLASH) begin
            mode_p = MODE_IDLE;
            star_p = 1'b0;
          end else begin
            star_p = (c == CH_STAR);
          end
        end
        MODE_IDENT: begin
          if (ch_alpha(c) || ch_digit(c) || c == CH_UNDER) begin
            add_char(c);
          end else begin
            flush_lexeme();
            start_fresh(c);
          end
        end
        MODE_NUM: begin
          if (ch_digit(c)) begin
            add_char(c);
          end else begin
            flush_lexeme();
            start_fresh(c);
          end
        end
        default: start_fresh(c);
      endcase
    end
  endfunction

  function automatic void add_text(input logic [7:0] b, input logic eot);
    text_item_t it;
    it.b   = b;
    it.eot = eot;
    text_q.push_back(it);
  endfunction

  function automatic logic [7:0] pick(input string s);
    return s[$urandom_range(s.len() - 1, 0)];
  endfunction

  // one random C-like fragment: mostly tokens and comments, some noise
  function automatic void gen_fragment();
    int sel;
    int n;
    string s;
    sel = $urandom_range(99, 0);
    if (sel < 25) begin
      n = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 30) : $urandom_range(8, 1);
      add_text(pick(head_chars), 1'b0);
      for (int i = 1; i < n; i++) add_text(pick(id_chars), 1'b0);
    end else if (sel < 35) begin
      s = kw_name[$urandom_range(5, 0)];
      for (int i = 0; i < s.len(); i++) add_text(s[i], 1'b0);
      if ($urandom_range(3, 0) == 0) add_text(pick(id_chars), 1'b0);
    end else if (sel < 50) begin
      n = ($urandom_range(11, 0) == 0) ? $urandom_range(36, 31) : $urandom_range(6, 1);
      for (int i = 0; i < n; i++) add_text(8'("0" + $urandom_range(9, 0)), 1'b0);
    end else if (sel < 65) begin
      add_text(pick(op_chars), 1'b0);
    end else if (sel < 75) begin
      add_text(pick(" \n\t"), 1'b0);
    end else if (sel < 82) begin
      add_text(CH_SLASH, 1'b0);
      add_text(CH_SLASH, 1'b0);
      n = $urandom_range(10, 0);
      for (int i = 0; i < n; i++) add_text(pick(cm_chars), 1'b0);
      if ($urandom_range(3, 0) == 0) add_text(8'($urandom_range(255, 0)), 1'b1);
      else add_text(CH_NL, 1'b0);
    end else if (sel < 90) begin
      add_text(CH_SLASH, 1'b0);
      add_text(CH_STAR, 1'b0);
      n = $urandom_range(12, 0);
      for (int i = 0; i < n; i++) add_text(pick(cm_chars), 1'b0);
      if ($urandom_range(5, 0) == 0) begin
        add_text(8'($urandom_range(255, 0)), 1'b1);
      end else begin
        add_text(CH_STAR, 1'b0);
        add_text(CH_SLASH, 1'b0);
      end
    end else if (sel < 97) begin
      add_text(8'($urandom_range(255, 0)), 1'b0);
    end else begin
      add_text(8'($urandom_range(255, 0)), 1'b1);
    end
    if ($urandom_range(1, 0) == 0) add_text(" ", 1'b0);
  endfunction

  task automatic send_text(input logic [7:0] b, input logic eot);
    int gap;
    gap = s_rush ? 0 : $urandom_range(16, 0);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eot;
    do @(posedge clk_i); while (!s_tready_o);
    n_bytes++;
  endtask

  task automatic feed_text(input logic [7:0] b, input logic eot);
    send_text(b, eot);
    lex_predict(b, eot);
  endtask

  function automatic void flag_miss(input string what, input lex_word_t want,
                                    input lex_word_t got);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("%s: want line %0d tok %0d kind %0d ch %h pos %0d last %b trunc %b",
               what, want.line, want.tok, want.kind, want.ch, want.pos, want.last, want.trunc);
      $display("      got  line %0d tok %0d kind %0d ch %h pos %0d last %b trunc %b",
               got.line, got.tok, got.kind, got.ch, got.pos, got.last, got.trunc);
    end
  endfunction

  // output side: random stalls per word
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = m_rush ? 0 : $urandom_range(16, 0);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid_o);
      if ($urandom_range(19, 0) == 0) m_rush = ~m_rush;
    end
  end

  always @(posedge clk_i) begin
    lex_word_t got;
    if (rst_ni && m_tvalid_o && m_tready) begin
      got = {m_tdata_o[15:0], m_tdata_o[31:16], m_tuser_o[1:0], m_tdata_o[39:32],
             m_tdata_o[44:40], m_tlast_o, m_tuser_o[2]};
      n_words++;
      if (m_tlast_o) n_tokens++;
      if (token_chars_q.size() == 0) flag_miss("unexpected word", NO_WORD, got);
      else if (got !== token_chars_q[0]) flag_miss("word mismatch", token_chars_q[0], got);
      if (token_chars_q.size() != 0) token_chars_q.pop_front();
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, token_chars_q.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    text_item_t it;
    int mark;
    int n_rand;
    n_rand = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NDIR; i++) begin
      s_rush = ($urandom_range(2, 0) == 0);
      send_text(dir_rows[i].b, dir_rows[i].eot);
      mark = push_cnt;
      lex_predict(dir_rows[i].b, dir_rows[i].eot);
      if (dir_rows[i].chk) begin
        if (push_cnt == mark + 1) token_chars_q[$] = dir_rows[i].want;
        else flag_miss("table row gives no single word", dir_rows[i].want, NO_WORD);
      end
    end

    while (n_rand < RAND_ITEMS) begin
      s_rush = ($urandom_range(3, 0) == 0);
      gen_fragment();
      while (text_q.size() != 0) begin
        it = text_q.pop_front();
        feed_text(it.b, it.eot);
        n_rand++;
      end
    end
    feed_text(8'h00, 1'b1);
    s_tvalid <= 1'b0;

    while (token_chars_q.size() != 0) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);

    $display("sent %0d text bytes, checked %0d words in %0d tokens", n_bytes, n_words, n_tokens);
    $display("comments, keywords, overlong lexemes, end-of-text flushes, gaps and stalls");
    if (err_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/cslex_pkg.sv
src/cslex_ram.sv
src/cslex_ctrl.sv
src/cslex_datapath.sv
src/c_subset_lexer_core.sv
verif/tb.sv
